### rtl/i2cm_pkg.sv
// Package: I2C master bit engine commands, widths and stream field positions.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  // Phase delay counter width
  localparam int unsigned DELAY_WIDTH = 16;
  localparam int unsigned CFG_WIDTH   = 16;

  // Command codes
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_WRITE   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_WAITACK = 3'd5;
  localparam logic [2:0] CMD_ACK     = 3'd6;
  localparam logic [2:0] CMD_NACK    = 3'd7;

  // Stream widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Result bit positions in out_tdata
  localparam int unsigned OUT_SCL  = 0;
  localparam int unsigned OUT_SDA  = 1;
  localparam int unsigned OUT_BUSY = 2;
  localparam int unsigned OUT_DONE = 3;
  localparam int unsigned OUT_RD_LO = 4;
  localparam int unsigned OUT_ACK  = 12;

  typedef logic [OUT_TDATA_W-1:0] out_word_t;

endpackage
`default_nettype wire

### rtl/i2c_master_bit_engine.sv
// Top level: I2C master bit engine, one bus tick per input transfer.
//
//   channel | direction | payload
//   in_     | slave     | tdata: mode, data_byte, sda_in
//   out_    | master    | tdata: scl_out, sda_out, busy_res, done_res, read_data, ack_bit
//   cfg_    | write     | delay_ticks
//
// Every accepted input transfer yields exactly one result transfer; the engine
// state advances once per transfer; one item is taken every cycle while in_tready is high.
// The result register plus a one-entry skid stage keep the input open while a
// result waits. Reset (rst_n low, synchronous) idles the bus with SCL and SDA
// high and empties both output stages. in_tready drops only while the skid
// stage holds a result.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_bit_engine (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // [2:0] mode, [10:3] data_byte, [11] sda_in, [15:12] zero
  input  wire  [i2cm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
  // [12] ack_bit, [15:13] zero
  output logic [i2cm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire                                 cfg_wr_en,
  input  wire  [i2cm_pkg::CFG_WIDTH-1:0]      cfg_wr_data
);
  import i2cm_pkg::*;

  // Configuration
  logic [CFG_WIDTH-1:0]   delay_ticks_r;

  // Engine state
  logic [1:0]             phase_r,    phase_nxt;
  logic [2:0]             bit_idx_r,  bit_idx_nxt;
  logic [DELAY_WIDTH-1:0] dly_cnt_r,  dly_cnt_nxt;
  logic [7:0]             shift_r,    shift_nxt;
  logic [2:0]             cmd_r,      cmd_nxt;
  logic                   scl_r,      scl_nxt;
  logic                   sda_r,      sda_nxt;
  logic                   busy_r,     busy_nxt;
  logic                   ack_r,      ack_nxt;
  logic [7:0]             rd_hold_r,  rd_hold_nxt;
  logic                   done_nxt;

  // Output stages
  out_word_t              out_data_r, skid_data_r, result;
  logic                   out_valid_r, skid_valid_r;

  logic                   accept;
  logic [2:0]             in_mode;
  logic [7:0]             in_byte;
  logic                   in_sda;
  logic [DELAY_WIDTH-1:0] dly_load;
  logic [1:0]             last_phase;
  logic                   do_enter;

  assign in_mode = in_tdata[2:0];
  assign in_byte = in_tdata[10:3];
  assign in_sda  = in_tdata[11];
  assign accept  = in_tvalid && in_tready;

  // Delay reload, zero counts as one
  always_comb begin
    dly_load = DELAY_WIDTH'(delay_ticks_r);
    if (dly_load == '0) begin
      dly_load = DELAY_WIDTH'(1);
    end
  end

  // Last phase index of one bit for the running command
  always_comb begin
    case (cmd_r)
      CMD_STOP: last_phase = 2'd0;
      CMD_READ: last_phase = 2'd1;
      default:  last_phase = 2'd2;
    endcase
  end

  // Next engine state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    dly_cnt_nxt = dly_cnt_r;
    shift_nxt   = shift_r;
    cmd_nxt     = cmd_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    busy_nxt    = busy_r;
    ack_nxt     = ack_r;
    rd_hold_nxt = rd_hold_r;
    done_nxt    = 1'b0;
    do_enter    = 1'b0;

    if (busy_r) begin
      dly_cnt_nxt = dly_cnt_r - DELAY_WIDTH'(1);
      if (dly_cnt_nxt == '0) begin
        // sample at the end of a high-SCL phase
        if (cmd_r == CMD_READ && phase_r == 2'd0) begin
          shift_nxt = {shift_r[6:0], in_sda};
        end else if (cmd_r == CMD_WAITACK && phase_r == 2'd1) begin
          ack_nxt = in_sda;
        end
        if (phase_r == last_phase) begin
          phase_nxt = 2'd0;
          if ((cmd_r == CMD_WRITE || cmd_r == CMD_READ) && bit_idx_r != 3'd7) begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            do_enter    = 1'b1;
          end else begin
            // command finished
            if (cmd_r == CMD_STOP || cmd_r == CMD_ACK) begin
              sda_nxt = 1'b1;
            end
            if (cmd_r == CMD_READ) begin
              rd_hold_nxt = shift_nxt;
            end
            busy_nxt    = 1'b0;
            bit_idx_nxt = 3'd0;
            dly_cnt_nxt = '0;
            cmd_nxt     = CMD_NONE;
            done_nxt    = 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
          do_enter  = 1'b1;
        end
      end
    end else if (in_mode != CMD_NONE) begin
      cmd_nxt     = in_mode;
      phase_nxt   = 2'd0;
      bit_idx_nxt = 3'd0;
      shift_nxt   = (in_mode == CMD_WRITE) ? in_byte : 8'd0;
      busy_nxt    = 1'b1;
      do_enter    = 1'b1;
    end

    // Line changes on phase entry
    if (do_enter) begin
      case (cmd_nxt)
        CMD_START: begin
          if (phase_nxt == 2'd0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else if (phase_nxt == 2'd1) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        CMD_STOP: begin
          sda_nxt = 1'b0;
          scl_nxt = 1'b1;
        end
        CMD_WRITE: begin
          if (phase_nxt == 2'd0) begin
            sda_nxt = shift_nxt[7];
          end else if (phase_nxt == 2'd1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
            if (bit_idx_nxt == 3'd7) begin
              sda_nxt = 1'b1;
            end
            shift_nxt = {shift_nxt[6:0], 1'b0};
          end
        end
        CMD_READ: begin
          scl_nxt = (phase_nxt == 2'd0);
        end
        default: begin
          // wait ack, ack, nack
          if (phase_nxt == 2'd0) begin
            sda_nxt = (cmd_nxt != CMD_ACK);
          end else if (phase_nxt == 2'd1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
      endcase
      dly_cnt_nxt = dly_load;
    end
  end

  // Pack the result word
  always_comb begin
    result           = '0;
    result[OUT_SCL]  = scl_nxt;
    result[OUT_SDA]  = sda_nxt;
    result[OUT_BUSY] = busy_nxt;
    result[OUT_DONE] = done_nxt;
    result[OUT_RD_LO +: 8] = rd_hold_nxt;
    result[OUT_ACK]  = ack_nxt;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r <= CFG_WIDTH'(100);
    end else if (cfg_wr_en) begin
      delay_ticks_r <= cfg_wr_data;
    end
  end

  // Engine state advances on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 2'd0;
      bit_idx_r <= 3'd0;
      dly_cnt_r <= '0;
      shift_r   <= 8'd0;
      cmd_r     <= CMD_NONE;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      busy_r    <= 1'b0;
      ack_r     <= 1'b0;
      rd_hold_r <= 8'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      dly_cnt_r <= dly_cnt_nxt;
      shift_r   <= shift_nxt;
      cmd_r     <= cmd_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      busy_r    <= busy_nxt;
      ack_r     <= ack_nxt;
      rd_hold_r <= rd_hold_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/i2cm_checker.sv
// Checker: port-level properties of the I2C master bit engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tready,
  input  wire  [i2cm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                              out_tvalid,
  input  wire                              out_tready
);
  import i2cm_pkg::*;

  // Reset empties the result stage
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Input only closes while a result is waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // A finishing tick reports the engine idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE] |-> !out_tdata[OUT_BUSY])
    else $error("done while busy");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
`default_nettype wire
